// ===== hw/rtl/tcis_pkg.sv =====
// ============================================================================
// tcis_pkg: shared types and constants for the toy CPU instruction step
// Item and result structs, controller state codes, opcodes and the
// command/status bundles that join the controller and the datapath.
// ============================================================================
package tcis_pkg;

    localparam int MEM_BYTES_DEF = 32768;
    localparam int NUM_REGS_DEF  = 16;

    typedef struct packed {
        logic        req_type;
        logic [14:0] load_addr;
        logic [7:0]  load_byte;
        logic [15:0] in_value;
    } item_t;

    typedef struct packed {
        logic        halted;
        logic        out_valid;
        logic [15:0] out_value;
        logic [14:0] pc_now;
        logic [1:0]  cmp_flag;
        logic [15:0] instr_word;
        logic        div_fault;
    } result_t;

    localparam logic [7:0] OP_HALT = 8'd0;
    localparam logic [7:0] OP_MOV  = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_SUB  = 8'd3;
    localparam logic [7:0] OP_MUL  = 8'd4;
    localparam logic [7:0] OP_DIV  = 8'd5;
    localparam logic [7:0] OP_AND  = 8'd6;
    localparam logic [7:0] OP_OR   = 8'd7;
    localparam logic [7:0] OP_NOT  = 8'd8;
    localparam logic [7:0] OP_CMP  = 8'd9;
    localparam logic [7:0] OP_JMP  = 8'd10;
    localparam logic [7:0] OP_IN   = 8'd11;
    localparam logic [7:0] OP_OUT  = 8'd12;

    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_GT = 2'd1;
    localparam logic [1:0] CMP_LT = 2'd2;

    localparam logic [7:0] NIB_HI_MASK = 8'd240;
    localparam logic [7:0] NIB_LO_MASK = 8'd15;

    // Byte-wide memory address select
    typedef enum logic [2:0] {
        AS_FETCH,    // code base + pc + offset
        AS_OPND,     // operand address + offset
        AS_DST,      // destination register value + offset
        AS_LOAD      // load item address
    } addr_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
        ST_DEC,
        ST_O0, ST_O1, ST_O2,
        ST_EXEC,
        ST_DIV,
        ST_W0, ST_W1,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       mem_rd;      // issue a memory read
        logic       mem_wr;      // write a byte
        addr_sel_t  asel;
        logic       aoff;        // +1 byte offset
        logic [1:0] byte_slot;   // 0 ir hi,1 ir lo,2 imm hi,3 imm lo (fetch)
        logic       cap_fetch;   // capture read data into fetch word
        logic       cap_opnd_hi;
        logic       cap_opnd_lo;
        logic       wr_lo;       // write data low byte vs high
        logic       latch_item;
        logic       exec;        // commit register/flag/pc update
        logic       div_start;
        logic       div_commit;
        logic       emit;
        logic       step_noop;   // halted step
        logic       load_item;
    } cmd_t;

    typedef struct packed {
        logic       is_step;
        logic       halted;
        logic [7:0] op;
        logic [3:0] src;
        logic       div_done;
    } stat_t;

endpackage

// ===== hw/rtl/tcis_div.sv =====
// ============================================================================
// tcis_div: 16-bit signed restoring divider
// One quotient bit per cycle on magnitudes, sign fixed at the end.
// ============================================================================
module tcis_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;
    logic [16:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, quo_reg[15]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend[15] ? 16'(-dividend) : dividend;
            dvs_next  = divisor[15] ? 16'(-divisor) : divisor;
            neg_next  = dividend[15] ^ divisor[15];
            rem_next  = '0;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = !busy_reg && !start;
    assign quotient = neg_reg ? 16'(-quo_reg) : quo_reg;
endmodule

// ===== hw/rtl/tcis_datapath.sv =====
// ============================================================================
// tcis_datapath: memory, register file and architectural state
// Byte memory with one registered read port, fetch and operand word
// assembly, ALU, and the result register.
// ============================================================================
module tcis_datapath #(
    parameter int MEM_BYTES = tcis_pkg::MEM_BYTES_DEF,
    parameter int NUM_REGS  = tcis_pkg::NUM_REGS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tcis_pkg::cmd_t   cmd,
    output tcis_pkg::stat_t  stat,
    input  tcis_pkg::item_t  item,
    input  logic [14:0]      code_base,
    output tcis_pkg::result_t res,
    output logic             res_strobe
);
    import tcis_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  rdata_reg;
    logic [15:0] rf_reg [NUM_REGS];
    logic [14:0] pc_reg;
    logic [1:0]  cmp_reg;
    logic        halt_reg;
    logic [15:0] last_reg;
    item_t       item_reg;
    logic [15:0] ir_reg, imm_reg, opnd_reg;
    result_t     res_reg, res_next;
    logic        strobe_reg;

    logic [7:0]  op;
    logic [3:0]  src, dst;
    logic [15:0] dval, sval;
    logic [16:0] fetch_base, addr_wide;
    logic [AW-1:0] addr;
    logic [7:0]  wdata;
    logic [15:0] alu;
    logic        wr_reg_en;
    logic        taken;
    logic        fault;
    logic        div_done;
    logic [15:0] div_q;
    logic        is_store;

    assign op  = ir_reg[15:8];
    assign src = 4'(ir_reg[7:0] & NIB_LO_MASK);
    assign dst = 4'((ir_reg[7:0] & NIB_HI_MASK) >> 4);
    assign dval = (32'(dst) < NUM_REGS) ? rf_reg[dst[$clog2(NUM_REGS)-1:0]] : 16'd0;
    assign sval = (32'(src) < NUM_REGS) ? rf_reg[src[$clog2(NUM_REGS)-1:0]] : 16'd0;
    assign fetch_base = 17'(pc_reg) + 17'(code_base);
    assign is_store = (op == OP_MOV) && (src != 4'd0) && (src < 4'd5);

    always_comb
    begin
        case (cmd.asel)
            AS_FETCH: addr_wide = fetch_base + 17'(cmd.byte_slot);
            AS_OPND:  addr_wide = (src == 4'd0) ? fetch_base + 17'd2 + 17'(cmd.aoff)
                                                : 17'(sval) + 17'(cmd.aoff);
            AS_DST:   addr_wide = 17'(dval) + 17'(cmd.aoff);
            AS_LOAD:  addr_wide = 17'(item_reg.load_addr);
            default:  addr_wide = '0;
        endcase
    end
    // Memory size is a power of two: wrap by dropping the upper address bits
    assign addr = addr_wide[AW-1:0];

    always_comb
    begin
        if (cmd.asel == AS_LOAD)
            wdata = item_reg.load_byte;
        else if (is_store)
            wdata = cmd.wr_lo ? sval[7:0] : sval[15:8];
        else
            wdata = cmd.wr_lo ? {7'd0, opnd_reg == 16'd0} : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[addr] <= wdata;
        if (cmd.mem_rd)
            rdata_reg <= mem[addr];
    end

    tcis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dval),
        .divisor  (opnd_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        alu       = 16'd0;
        wr_reg_en = 1'b0;
        taken     = 1'b0;
        case (op)
            OP_MOV: begin alu = opnd_reg; wr_reg_en = !is_store; end
            OP_ADD: begin alu = dval + opnd_reg; wr_reg_en = 1'b1; end
            OP_SUB: begin alu = dval - opnd_reg; wr_reg_en = 1'b1; end
            OP_MUL: begin alu = 16'(dval * opnd_reg); wr_reg_en = 1'b1; end
            OP_AND: begin alu = {15'd0, (dval & opnd_reg) != 16'd0}; wr_reg_en = 1'b1; end
            OP_OR:  begin alu = {15'd0, (dval | opnd_reg) != 16'd0}; wr_reg_en = 1'b1; end
            OP_NOT: begin alu = {15'd0, dval == 16'd0}; wr_reg_en = (src == 4'd0); end
            OP_IN:  begin alu = item_reg.in_value; wr_reg_en = 1'b1; end
            OP_JMP: taken = (src == 4'd0) || (src == 4'd1 && cmp_reg == CMP_EQ)
                         || (src == 4'd2 && cmp_reg == CMP_GT)
                         || (src == 4'd3 && cmp_reg == CMP_LT);
            default: ;
        endcase
    end

    assign fault = (op == OP_DIV) && (opnd_reg == 16'd0);

    always_comb
    begin
        res_next            = res_reg;
        res_next.halted     = halt_reg;
        res_next.pc_now     = pc_reg;
        res_next.cmp_flag   = cmp_reg;
        res_next.instr_word = last_reg;
        if (cmd.load_item || cmd.step_noop)
        begin
            res_next.out_valid = 1'b0;
            res_next.out_value = '0;
            res_next.div_fault = 1'b0;
        end
        else
        begin
            res_next.out_valid = (op == OP_OUT);
            res_next.out_value = (op == OP_OUT) ? dval : 16'd0;
            res_next.div_fault = fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                rf_reg[i] <= '0;
            pc_reg     <= '0;
            cmp_reg    <= CMP_EQ;
            halt_reg   <= 1'b0;
            last_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.exec)
            begin
                last_reg <= ir_reg;
                if (op == OP_HALT)
                    halt_reg <= 1'b1;
                if (op == OP_CMP)
                    cmp_reg <= ($signed(dval) == $signed(opnd_reg)) ? CMP_EQ :
                               ($signed(dval) > $signed(opnd_reg)) ? CMP_GT : CMP_LT;
                if (wr_reg_en && 32'(dst) < NUM_REGS)
                    rf_reg[dst[$clog2(NUM_REGS)-1:0]] <= alu;
                pc_reg <= taken ? 15'(pc_reg + imm_reg[14:0]) : 15'(pc_reg + 15'd4);
            end
            if (cmd.div_commit && !fault && 32'(dst) < NUM_REGS)
                rf_reg[dst[$clog2(NUM_REGS)-1:0]] <= div_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
            item_reg <= item;
        if (cmd.cap_fetch)
        begin
            case (cmd.byte_slot)
                2'd1: ir_reg[15:8]  <= rdata_reg;
                2'd2: ir_reg[7:0]   <= rdata_reg;
                2'd3: imm_reg[15:8] <= rdata_reg;
                default: imm_reg[7:0] <= rdata_reg;
            endcase
        end
        if (cmd.cap_opnd_hi)
            opnd_reg[15:8] <= rdata_reg;
        if (cmd.cap_opnd_lo)
            opnd_reg[7:0] <= rdata_reg;
        if (cmd.emit)
            res_reg <= res_next;
    end

    assign stat.is_step  = item_reg.req_type;
    assign stat.halted   = halt_reg;
    assign stat.op       = op;
    assign stat.src      = src;
    assign stat.div_done = div_done;
    assign res           = res_reg;
    assign res_strobe    = strobe_reg;
endmodule

// ===== hw/rtl/tcis_ctrl.sv =====
// ============================================================================
// tcis_ctrl: sequencer for load and step items
// Walks fetch, operand read, execute, divide and store phases.
// ============================================================================
module tcis_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output tcis_pkg::cmd_t  cmd,
    input  tcis_pkg::stat_t stat
);
    import tcis_pkg::*;

    state_t state_reg, state_next;
    logic   needs_opnd;
    logic   is_store;
    logic   is_notmem;

    assign is_store  = (stat.op == OP_MOV) && (stat.src != 4'd0) && (stat.src < 4'd5);
    assign is_notmem = (stat.op == OP_NOT) && (stat.src != 4'd0);
    assign needs_opnd = !is_store && (stat.op == OP_MOV || stat.op == OP_ADD
        || stat.op == OP_SUB || stat.op == OP_MUL || stat.op == OP_DIV
        || stat.op == OP_AND || stat.op == OP_OR || stat.op == OP_CMP || is_notmem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.asel   = AS_FETCH;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_item = start;
                if (start)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!stat.is_step)
                begin
                    cmd.asel = AS_LOAD; cmd.mem_wr = 1'b1;
                    cmd.load_item = 1'b1; cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.halted)
                begin
                    cmd.step_noop = 1'b1; cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1; cmd.byte_slot = 2'd0;
                    state_next = ST_F0;
                end
            end
            // Each fetch state captures the previous byte; all but the last also read the next one
            ST_F0: begin cmd.mem_rd = 1'b1; cmd.byte_slot = 2'd1;
                cmd.cap_fetch = 1'b1; state_next = ST_F1; end
            ST_F1: begin cmd.mem_rd = 1'b1; cmd.byte_slot = 2'd2;
                cmd.cap_fetch = 1'b1; state_next = ST_F2; end
            ST_F2: begin cmd.mem_rd = 1'b1; cmd.byte_slot = 2'd3;
                cmd.cap_fetch = 1'b1; state_next = ST_F3; end
            ST_F3: begin cmd.byte_slot = 2'd0; cmd.cap_fetch = 1'b1;
                state_next = ST_DEC; end
            ST_DEC:
            begin
                if (needs_opnd)
                begin
                    cmd.asel = AS_OPND; cmd.mem_rd = 1'b1;
                    state_next = ST_O0;
                end
                else if (is_store)
                begin
                    cmd.asel = AS_DST; cmd.mem_wr = 1'b1;
                    state_next = ST_W1;
                end
                else
                    state_next = ST_EXEC;
            end
            ST_O0: begin cmd.asel = AS_OPND; cmd.aoff = 1'b1; cmd.mem_rd = 1'b1;
                cmd.cap_opnd_hi = 1'b1; state_next = ST_O1; end
            ST_O1: begin cmd.cap_opnd_lo = 1'b1; state_next = ST_O2; end
            ST_O2:
            begin
                if (stat.op == OP_DIV)
                begin
                    cmd.div_start = 1'b1; state_next = ST_DIV;
                end
                else if (is_notmem)
                begin
                    cmd.asel = AS_OPND; cmd.mem_wr = 1'b1;
                    state_next = ST_W0;
                end
                else
                    state_next = ST_EXEC;
            end
            ST_W0: begin cmd.asel = AS_OPND; cmd.aoff = 1'b1; cmd.wr_lo = 1'b1;
                cmd.mem_wr = 1'b1; state_next = ST_EXEC; end
            ST_W1: begin cmd.asel = AS_DST; cmd.aoff = 1'b1; cmd.wr_lo = 1'b1;
                cmd.mem_wr = 1'b1; state_next = ST_EXEC; end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_commit = 1'b1; state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin cmd.exec = 1'b1; state_next = ST_DONE; end
            ST_DONE: begin cmd.emit = 1'b1; state_next = ST_IDLE; end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule

// ===== hw/rtl/toy_cpu_instruction_step.sv =====
// ============================================================================
// toy_cpu_instruction_step: one core of a 16-bit teaching processor
// Byte-addressed big-endian memory, register file, serial fetch and divide.
//
//  channel | signals                     | transfer
//  --------+-----------------------------+----------------------------------
//  item    | start, busy, item           | start && !busy at clk rise
//  result  | done, result                | done high for one cycle
//  config  | psel..prdata (APB)          | psel && penable && pwrite
//
// A load writes its byte. A step fetches four bytes serially; then a store
// writes two bytes, an operand word is read bytewise, a memory not writes
// two bytes back or a divide waits on the one-bit-per-cycle divider, before
// execute. The next item is taken once busy falls, the cycle the result is
// shown. The result cannot be stalled. Reset is asynchronous; memory contents
// are not cleared. MEM_BYTES must be a power of two; nothing enforces it.
// ============================================================================
module toy_cpu_instruction_step #(
    parameter int MEM_BYTES = tcis_pkg::MEM_BYTES_DEF,
    parameter int NUM_REGS  = tcis_pkg::NUM_REGS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcis_pkg::item_t   item,
    output logic              done,
    output tcis_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tcis_pkg::*;

    logic [14:0] code_base_reg;
    cmd_t        cmd;
    stat_t       stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_base_reg <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0)
            code_base_reg <= pwdata[14:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {17'd0, code_base_reg} : 32'd0;

    tcis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    tcis_datapath #(
        .MEM_BYTES (MEM_BYTES),
        .NUM_REGS  (NUM_REGS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .item       (item),
        .code_base  (code_base_reg),
        .res        (result),
        .res_strobe (done)
    );
endmodule
